// File: src/rat_pkg.sv
// Shared types and codes for the repeating alarm timer.
// Used by every module of the block; depends on nothing.
package rat_pkg;

  localparam int unsigned MsPerSecond = 1000;

  typedef enum logic [2:0] {
    OP_CHECK  = 3'd0,
    OP_DEFINE = 3'd1,
    OP_START  = 3'd2,
    OP_PAUSE  = 3'd3,
    OP_FINISH = 3'd4,
    OP_CLEAR  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    UNIT_SEC  = 2'd0,
    UNIT_MSEC = 2'd1,
    UNIT_USEC = 2'd2
  } unit_t;

  typedef enum logic [1:0] {
    REG_PERIOD       = 2'd0,
    REG_REPEAT_COUNT = 2'd1,
    REG_TIME_UNIT    = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] now_ms;
    logic [31:0] now_us;
  } in_item_t;

  typedef struct packed {
    logic               fired;
    logic signed [15:0] remaining;
    logic [2:0]         phase;
  } out_item_t;

  // Live configuration; period_ms holds period scaled to milliseconds for seconds mode.
  typedef struct packed {
    logic [31:0]        period;
    logic [41:0]        period_ms;
    logic signed [15:0] repeat_count;
    logic [1:0]         time_unit;
  } cfg_t;

endpackage

// File: src/rat_cfg_regs.sv
// Configuration registers of the repeating alarm timer.
// Depends on rat_pkg for the register indexes and the cfg_t struct.
module rat_cfg_regs
  import rat_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output cfg_t        cfg
);

  cfg_t        cfg_r;
  logic [41:0] wdata_ext;
  logic [41:0] wdata_x1000;

  // Times 1000 as 1024 - 16 - 8; cannot overflow 42 bits.
  assign wdata_ext   = {10'd0, cfg_wdata};
  assign wdata_x1000 = (wdata_ext << 10) - (wdata_ext << 4) - (wdata_ext << 3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.period       <= 32'd0;
      cfg_r.period_ms    <= 42'd0;
      cfg_r.repeat_count <= 16'sd1;
      cfg_r.time_unit    <= UNIT_MSEC;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PERIOD: begin
          cfg_r.period    <= cfg_wdata;
          cfg_r.period_ms <= wdata_x1000;
        end
        REG_REPEAT_COUNT: cfg_r.repeat_count <= cfg_wdata[15:0];
        REG_TIME_UNIT:    cfg_r.time_unit    <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

  a_scaled_period: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && cfg_index == REG_PERIOD |=>
      cfg_r.period_ms == 42'(cfg_r.period) * 42'(MsPerSecond))
    else $error("scaled period does not match period");

endmodule

// File: src/rat_core.sv
// Command decode and alarm state of the repeating alarm timer.
// Depends on rat_pkg; state advances once per enabled transaction.
module rat_core
  import rat_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t result
);

  typedef enum logic [2:0] {
    PH_UNDEFINED = 3'd0,
    PH_READY     = 3'd1,
    PH_RUNNING   = 3'd2,
    PH_PAUSED    = 3'd3,
    PH_FINISHED  = 3'd4
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [31:0]        ref_r, ref_nxt;
  logic signed [15:0] repeats_r, repeats_nxt;

  logic [31:0] stamp;
  logic [31:0] diff_ms;
  logic [31:0] diff_us;
  logic        due;
  logic        fired;

  assign diff_ms = item.now_ms - ref_r;
  assign diff_us = item.now_us - ref_r;
  assign stamp   = (cfg.time_unit == UNIT_USEC) ? item.now_us : item.now_ms;

  // Seconds mode: floor(diff / 1000) >= period is the same as diff >= period * 1000.
  always_comb begin
    case (cfg.time_unit)
      UNIT_SEC:  due = {10'd0, diff_ms} >= cfg.period_ms;
      UNIT_MSEC: due = diff_ms >= cfg.period;
      UNIT_USEC: due = diff_us >= cfg.period;
      default:   due = 1'b0;
    endcase
  end

  always_comb begin
    phase_nxt   = phase_r;
    ref_nxt     = ref_r;
    repeats_nxt = repeats_r;
    fired       = 1'b0;
    case (item.operation)
      OP_CHECK: begin
        if (phase_r == PH_RUNNING && due) begin
          fired   = 1'b1;
          ref_nxt = stamp;
          if (repeats_r > 16'sd0) begin
            repeats_nxt = repeats_r - 16'sd1;
            if (repeats_r == 16'sd1) begin
              phase_nxt = PH_FINISHED;
            end
          end
        end
      end
      OP_DEFINE: begin
        phase_nxt   = PH_READY;
        repeats_nxt = cfg.repeat_count;
      end
      OP_START: begin
        if (phase_r inside {PH_READY, PH_PAUSED, PH_FINISHED}) begin
          phase_nxt = PH_RUNNING;
          if (phase_r == PH_FINISHED) begin
            repeats_nxt = cfg.repeat_count;
          end
          // An unknown time unit still starts but keeps the old reference.
          if (cfg.time_unit inside {UNIT_SEC, UNIT_MSEC, UNIT_USEC}) begin
            ref_nxt = stamp;
          end
        end
      end
      OP_PAUSE: begin
        if (phase_r == PH_RUNNING) begin
          phase_nxt = PH_PAUSED;
        end
      end
      OP_FINISH: begin
        phase_nxt   = PH_FINISHED;
        repeats_nxt = 16'sd0;
      end
      OP_CLEAR: begin
        if (phase_r != PH_RUNNING) begin
          phase_nxt = PH_UNDEFINED;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_UNDEFINED;
      ref_r     <= 32'd0;
      repeats_r <= 16'sd0;
    end else if (en) begin
      phase_r   <= phase_nxt;
      ref_r     <= ref_nxt;
      repeats_r <= repeats_nxt;
    end
  end

  assign result.fired     = fired;
  assign result.remaining = (phase_nxt == PH_RUNNING) ? repeats_nxt : 16'sd0;
  assign result.phase     = phase_nxt;

  a_fire_on_check: assert property (@(posedge clk) disable iff (!rst_n)
    en && fired |-> item.operation == OP_CHECK && phase_r == PH_RUNNING)
    else $error("alarm fired outside a running check");

  a_finished_empty: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_FINISHED |-> repeats_r == 16'sd0)
    else $error("finished alarm still holds repeats");

  a_fire_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    en && fired |=> ref_r == $past(stamp))
    else $error("firing did not take a new reference");

endmodule

// File: src/repeating_alarm_timer.sv
// Repeating alarm timer top level: input register, alarm core, result register.
// Depends on rat_pkg, rat_cfg_regs and rat_core.
//
// Usage:
//   Input channel (in_valid, in_stall, in_data) carries one command per
//   transaction with the current millisecond and microsecond timestamps.
//   Result channel (out_valid, out_stall, out_data) returns exactly one
//   result per command: fired flag, remaining repeats and phase after it.
//   The configuration port (cfg_we, cfg_index, cfg_wdata) writes period,
//   repeat count and time unit; write it only while no command is in flight.
// Order: an accepted command waits in the input register; when it advances, its
//   result is loaded into the result register, which holds it while stalled.
// Throughput: one command per cycle while the result is not stalled; the command
//   logic is one registered pass between the input register and the result register.
// Reset: synchronous, active low; the alarm returns to the undefined phase
//   with cleared reference and counter, and the configuration registers take their defaults.
// Stall: a stalled result holds; the input register still takes one more
//   command, and only then is in_stall raised.
module repeating_alarm_timer
  import rat_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  cfg_t      cfg;
  in_item_t  in_data_r;
  logic      in_valid_r;
  out_item_t out_data_r;
  logic      out_valid_r;
  out_item_t result;
  logic      in_accept;
  logic      advance;

  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  rat_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rat_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (advance),
    .item   (in_data_r),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_valid_r && out_valid_r && out_stall)
    else $error("input stalled while the pipeline has room");

  a_no_lost_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && out_data_r == $past(out_data_r))
    else $error("stalled result was overwritten or dropped");

endmodule

// File: test/testbench.sv
// Self-checking testbench for repeating_alarm_timer: a directed script, then random
// command sessions, checked against listed results or an in-bench model of the alarm.
// Depends on rat_pkg and the repeating_alarm_timer RTL.
module testbench;
  import rat_pkg::*;

  localparam logic [2:0] PH_UNDEFINED = 3'd0;
  localparam logic [2:0] PH_READY     = 3'd1;
  localparam logic [2:0] PH_RUNNING   = 3'd2;
  localparam logic [2:0] PH_PAUSED    = 3'd3;
  localparam logic [2:0] PH_FINISHED  = 3'd4;
  localparam logic [2:0] OP_RSVD6     = 3'd6;
  localparam logic [2:0] OP_RSVD7     = 3'd7;
  localparam logic [1:0] UNIT_NONE    = 2'd3;
  localparam int RANDOM_ITEMS = 700;
  localparam int STALL_LIMIT  = 1000;
  localparam int PRINT_LIMIT  = 30;

  typedef struct packed {
    logic        is_cfg;
    logic [31:0] period;
    logic [15:0] repeats;
    logic [1:0]  unit;
    in_item_t    item;
    logic        known;
    out_item_t   want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;

  // Alarm model state and its copy of the registers.
  logic [2:0]  timer_phase;
  logic [31:0] mark_stamp;
  logic [15:0] shots_left;
  logic [31:0] period_setting;
  logic [15:0] repeat_setting;
  logic [1:0]  unit_setting;

  out_item_t   expected_results[$];
  int          mismatches = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          fire_count = 0;
  int          settings_used = 0;
  bit          calm = 1'b1;
  logic [31:0] ms_clock;
  logic [31:0] us_clock;
  int          ms_step;
  int          us_step;

  repeating_alarm_timer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_LIMIT) $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  function automatic out_item_t alarm_step(input in_item_t cmd_in);
    out_item_t   res;
    logic [31:0] stamp;
    logic [31:0] span;
    res = '0;
    case (cmd_in.operation)
      OP_CHECK: begin
        if (timer_phase == PH_RUNNING && unit_setting != UNIT_NONE) begin
          stamp = (unit_setting == UNIT_USEC) ? cmd_in.now_us : cmd_in.now_ms;
          span = stamp - mark_stamp;
          if (unit_setting == UNIT_SEC) span = span / MsPerSecond;
          if (span >= period_setting) begin
            res.fired = 1'b1;
            fire_count++;
            mark_stamp = stamp;
            if ($signed(shots_left) > 0) begin
              shots_left = shots_left - 16'd1;
              if (shots_left == 16'd0) timer_phase = PH_FINISHED;
            end
          end
        end
      end
      OP_DEFINE: begin
        timer_phase = PH_READY;
        shots_left = repeat_setting;
      end
      OP_START: begin
        if (timer_phase == PH_FINISHED) shots_left = repeat_setting;
        if (timer_phase == PH_READY || timer_phase == PH_PAUSED ||
            timer_phase == PH_FINISHED) begin
          timer_phase = PH_RUNNING;
          // An unnamed unit code still starts the alarm but keeps the old reference.
          if (unit_setting == UNIT_USEC) mark_stamp = cmd_in.now_us;
          else if (unit_setting != UNIT_NONE) mark_stamp = cmd_in.now_ms;
        end
      end
      OP_PAUSE: begin
        if (timer_phase == PH_RUNNING) timer_phase = PH_PAUSED;
      end
      OP_FINISH: begin
        timer_phase = PH_FINISHED;
        shots_left = 16'd0;
      end
      OP_CLEAR: begin
        if (timer_phase != PH_RUNNING) timer_phase = PH_UNDEFINED;
      end
      default: ;
    endcase
    res.remaining = (timer_phase == PH_RUNNING) ? shots_left : 16'd0;
    res.phase = timer_phase;
    return res;
  endfunction

  function automatic stim_row_t cmd(input logic [2:0] op, input logic [31:0] ms,
                                    input logic [31:0] us, input logic known = 1'b0,
                                    input logic f = 1'b0, input logic [15:0] r = '0,
                                    input logic [2:0] p = '0);
    stim_row_t row;
    row = '0;
    row.item.operation = op;
    row.item.now_ms = ms;
    row.item.now_us = us;
    row.known = known;
    row.want.fired = f;
    row.want.remaining = r;
    row.want.phase = p;
    return row;
  endfunction

  function automatic stim_row_t setting(input logic [31:0] period,
                                        input logic [15:0] repeats, input logic [1:0] unit);
    stim_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.period = period;
    row.repeats = repeats;
    row.unit = unit;
    return row;
  endfunction

  // Builds the next random command, steering it by the phase the model is in.
  function automatic in_item_t next_command();
    in_item_t item;
    int       roll;
    roll = $urandom_range(0, 99);
    ms_clock = ms_clock + 32'($urandom_range(0, ms_step));
    us_clock = us_clock + 32'($urandom_range(0, us_step));
    item.now_ms = ms_clock;
    item.now_us = us_clock;
    if (roll < 8) begin
      item.operation = 3'($urandom_range(0, 7));
      item.now_ms = $urandom;
      item.now_us = $urandom;
      return item;
    end
    roll = $urandom_range(0, 99);
    case (timer_phase)
      PH_UNDEFINED: item.operation = (roll < 85) ? OP_DEFINE : OP_FINISH;
      PH_READY:     item.operation = (roll < 80) ? OP_START : (roll < 90) ? OP_CHECK : OP_CLEAR;
      PH_RUNNING: begin
        if (roll < 75)      item.operation = OP_CHECK;
        else if (roll < 81) item.operation = OP_PAUSE;
        else if (roll < 85) item.operation = OP_FINISH;
        else if (roll < 89) item.operation = OP_CLEAR;
        else if (roll < 93) item.operation = OP_START;
        else                item.operation = OP_DEFINE;
      end
      PH_PAUSED: begin
        if (roll < 70)      item.operation = OP_START;
        else if (roll < 80) item.operation = OP_CHECK;
        else if (roll < 90) item.operation = OP_CLEAR;
        else                item.operation = OP_FINISH;
      end
      default: begin
        if (roll < 60)      item.operation = OP_START;
        else if (roll < 80) item.operation = OP_DEFINE;
        else if (roll < 90) item.operation = OP_CHECK;
        else                item.operation = OP_CLEAR;
      end
    endcase
    return item;
  endfunction

  task automatic send_item(input in_item_t item, input logic known = 1'b0,
                           input out_item_t want = '0);
    int        gap;
    out_item_t predicted;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = alarm_step(item);
    expected_results.push_back(known ? want : predicted);
    items_sent++;
  endtask

  // Waits until every result is back and the pipeline has emptied.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic load_config(input logic [31:0] period, input logic [15:0] repeats,
                             input logic [1:0] unit);
    cfg_we <= 1'b1;
    cfg_index <= REG_PERIOD;
    cfg_wdata <= period;
    @(posedge clk);
    cfg_index <= REG_REPEAT_COUNT;
    cfg_wdata <= {16'd0, repeats};
    @(posedge clk);
    cfg_index <= REG_TIME_UNIT;
    cfg_wdata <= {30'd0, unit};
    @(posedge clk);
    cfg_we <= 1'b0;
    period_setting = period;
    repeat_setting = repeats;
    unit_setting = unit;
    settings_used++;
  endtask

  // Result checking, receiver stalls and the progress watchdog share one clocked block.
  always @(posedge clk) begin : result_side
    out_item_t want;
    int        rx_wait;
    int        quiet_cycles;
    if (rst_n === 1'b1) begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", out_data));
        end else begin
          want = expected_results.pop_front();
          if (out_data.fired !== want.fired)
            report_mismatch($sformatf("result %0d: fired %b, expected %b",
                                      results_seen, out_data.fired, want.fired));
          if (out_data.remaining !== want.remaining)
            report_mismatch($sformatf("result %0d: remaining %0d, expected %0d",
                                      results_seen, out_data.remaining, want.remaining));
          if (out_data.phase !== want.phase)
            report_mismatch($sformatf("result %0d: phase %0d, expected %0d",
                                      results_seen, out_data.phase, want.phase));
        end
        rx_wait = calm ? 0 : $urandom_range(0, 5);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_stall <= (rx_wait > 0);
      if ((out_valid === 1'b1 && out_stall === 1'b0) ||
          (in_valid === 1'b1 && in_stall === 1'b0))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("repeating_alarm_timer: mismatch");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t   script[$];
    logic [31:0] period;
    logic [15:0] repeats;
    logic [1:0]  unit;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_PERIOD;
    cfg_wdata = '0;
    timer_phase = PH_UNDEFINED;
    mark_stamp = '0;
    shots_left = '0;
    period_setting = '0;
    repeat_setting = 16'd1;
    unit_setting = UNIT_MSEC;

    // Reset defaults: period 0, one repeat, milliseconds.
    script.push_back(cmd(OP_CHECK, '0, '0, 1'b1, 1'b0, 16'd0, PH_UNDEFINED));
    script.push_back(cmd(OP_RSVD6, '1, '1, 1'b1, 1'b0, 16'd0, PH_UNDEFINED));
    script.push_back(cmd(OP_RSVD7, '0, '1, 1'b1, 1'b0, 16'd0, PH_UNDEFINED));
    script.push_back(cmd(OP_START, 32'd100, 32'd100, 1'b1, 1'b0, 16'd0, PH_UNDEFINED));
    script.push_back(cmd(OP_PAUSE, 32'd100, 32'd100, 1'b1, 1'b0, 16'd0, PH_UNDEFINED));
    script.push_back(cmd(OP_CLEAR, 32'd100, 32'd100, 1'b1, 1'b0, 16'd0, PH_UNDEFINED));
    script.push_back(cmd(OP_DEFINE, '0, '0, 1'b1, 1'b0, 16'd0, PH_READY));
    script.push_back(cmd(OP_START, 32'hFFFF_FFF0, '0, 1'b1, 1'b0, 16'd1, PH_RUNNING));
    script.push_back(cmd(OP_START, '0, '0, 1'b1, 1'b0, 16'd1, PH_RUNNING));
    script.push_back(cmd(OP_CLEAR, '0, '0, 1'b1, 1'b0, 16'd1, PH_RUNNING));
    // The elapsed time wraps through zero here.
    script.push_back(cmd(OP_CHECK, 32'd5, '0, 1'b1, 1'b1, 16'd0, PH_FINISHED));
    script.push_back(cmd(OP_START, 32'd16, '0, 1'b1, 1'b0, 16'd1, PH_RUNNING));
    script.push_back(cmd(OP_PAUSE, 32'd20, '0, 1'b1, 1'b0, 16'd0, PH_PAUSED));
    script.push_back(cmd(OP_START, '1, '0, 1'b1, 1'b0, 16'd1, PH_RUNNING));
    script.push_back(cmd(OP_FINISH, '1, '0, 1'b1, 1'b0, 16'd0, PH_FINISHED));
    script.push_back(cmd(OP_CLEAR, '1, '0, 1'b1, 1'b0, 16'd0, PH_UNDEFINED));
    // Finishing an undefined alarm still lets a later start run it.
    script.push_back(cmd(OP_FINISH, '0, '0, 1'b1, 1'b0, 16'd0, PH_FINISHED));
    script.push_back(cmd(OP_START, '0, '0, 1'b1, 1'b0, 16'd1, PH_RUNNING));
    script.push_back(cmd(OP_CHECK, '1, '0, 1'b1, 1'b1, 16'd0, PH_FINISHED));
    // Largest period in microseconds, endless repeats.
    script.push_back(setting('1, 16'hFFFF, UNIT_USEC));
    script.push_back(cmd(OP_DEFINE, '0, '0, 1'b1, 1'b0, 16'd0, PH_READY));
    script.push_back(cmd(OP_START, '0, '1, 1'b1, 1'b0, 16'hFFFF, PH_RUNNING));
    script.push_back(cmd(OP_CHECK, '0, 32'hFFFF_FFFE, 1'b1, 1'b1, 16'hFFFF, PH_RUNNING));
    script.push_back(cmd(OP_CHECK, '0, '1, 1'b1, 1'b0, 16'hFFFF, PH_RUNNING));
    // With the unnamed unit code a check never fires, even at period zero.
    script.push_back(setting('0, 16'd2, UNIT_NONE));
    script.push_back(cmd(OP_PAUSE, '1, '1, 1'b1, 1'b0, 16'd0, PH_PAUSED));
    script.push_back(cmd(OP_START, '0, '0, 1'b1, 1'b0, 16'hFFFF, PH_RUNNING));
    script.push_back(cmd(OP_CHECK, '1, '1, 1'b1, 1'b0, 16'hFFFF, PH_RUNNING));
    script.push_back(cmd(OP_CHECK, 32'h8000_0000, 32'h8000_0000));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        settle();
        load_config(script[i].period, script[i].repeats, script[i].unit);
      end else begin
        send_item(script[i].item, script[i].known, script[i].want);
      end
    end

    ms_clock = $urandom;
    us_clock = $urandom;
    while (items_sent < RANDOM_ITEMS) begin
      settle();
      unit = ($urandom_range(0, 7) == 0) ? UNIT_NONE : 2'($urandom_range(0, 2));
      case (unit)
        UNIT_SEC:  period = $urandom_range(0, 3);
        UNIT_USEC: period = $urandom_range(0, 200);
        default:   period = $urandom_range(0, 40);
      endcase
      ms_step = (unit == UNIT_SEC) ? 600 : 15;
      us_step = 60;
      case ($urandom_range(0, 9))
        0: period = '0;
        1: period = '1;
        2: period = $urandom;
        default: ;
      endcase
      case ($urandom_range(0, 7))
        0: repeats = 16'hFFFF;
        1: repeats = 16'd0;
        2: repeats = 16'h7FFF;
        3: repeats = 16'($urandom);
        default: repeats = 16'($urandom_range(1, 4));
      endcase
      load_config(period, repeats, unit);
      calm = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(10, 40)) send_item(next_command());
    end

    settle();
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    $display("Sent %0d commands under %0d timer settings; the alarm fired %0d times.",
             items_sent, settings_used, fire_count);
    $display("Compared %0d results, %0d field mismatches.", results_seen, mismatches);
    if (mismatches == 0)
      $display("repeating_alarm_timer: match");
    else
      $display("repeating_alarm_timer: mismatch");
    $finish;
  end

endmodule

// File: repeating_alarm_timer.f
src/rat_pkg.sv
src/rat_cfg_regs.sv
src/rat_core.sv
src/repeating_alarm_timer.sv
test/testbench.sv
